@@ rtl/crr_pkg.sv @@
// Shared types, codes and stream layout for the chained range remap block.
package crr_pkg;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_FWD    = 3'd1,
        OP_REV    = 3'd2,
        OP_COUNT  = 3'd3,
        OP_MINRST = 3'd4
    } t_opcode;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    localparam int OPCODE_W = 3;
    localparam int STAGE_W  = 3;
    localparam int INDEX_W  = 5;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 6;

    // Request layout in s_axis_tdata
    localparam int STAGE_LSB = 0;
    localparam int INDEX_LSB = STAGE_LSB + STAGE_W;
    localparam int DEST_LSB  = INDEX_LSB + INDEX_W;
    localparam int SRC_LSB   = DEST_LSB + FIELD_W;
    localparam int LEN_LSB   = SRC_LSB + FIELD_W;
    localparam int COUNT_LSB = LEN_LSB + FIELD_W;
    localparam int VALUE_LSB = COUNT_LSB + COUNT_W;
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = OPCODE_W;

    // Result layout in m_axis_tdata
    localparam int MAPPED_LSB = 0;
    localparam int LOWEST_LSB = MAPPED_LSB + FIELD_W;
    localparam int STATUS_LSB = LOWEST_LSB + FIELD_W;
    localparam int M_TDATA_W  = 72;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

@@ rtl/chained_range_remap.sv @@
// Chained range remap: STAGES range translation tables walked forward or in reverse.
// A request of any kind but a map passes from idle to the done state, and its result
// is registered from there as soon as the output register is free. A forward or
// reverse map walks the stages in order, leaving a stage at the first entry that
// matches or after the stage's entry count: the entry memory has one read port
// and one entry is compared per cycle. One request is worked on at a time; the next is
// taken as soon as the result sits in the output register, even while that result
// waits to be taken.
module chained_range_remap
    import crr_pkg::*;
#(
    parameter int STAGES      = 7,
    parameter int ENTRIES     = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // stage_sel, entry_index, dest_start, source_start, range_length,
    // entry_count, value_in, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // mapped_value, lowest_seen, status, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int VW     = VALUE_WIDTH;
    localparam int DEPTH  = STAGES * ENTRIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int EW     = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAP  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [EW-1:0]   r_counts [STAGES];
    logic [VW-1:0]   r_min;
    logic [VW-1:0]   r_val;
    logic [VW-1:0]   r_res_val;
    logic            r_res_status;
    logic [SW-1:0]   r_stage;
    logic [EW-1:0]   r_ent;
    logic            r_pend;
    logic            r_rev;
    logic            r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic                w_accept;
    t_opcode             w_opcode;
    logic [STAGE_W-1:0]  w_stage_sel;
    logic [INDEX_W-1:0]  w_entry_index;
    logic [COUNT_W-1:0]  w_entry_count;
    logic                w_stage_ok;
    logic                w_idx_ok;
    logic                w_cnt_ok;
    logic                w_reject;
    t_mem_ctl            w_ctl;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [3*VW-1:0]     w_wr_data;
    logic [3*VW-1:0]     w_rd_data;
    logic [VW-1:0]       w_dest, w_src, w_len;
    logic [VW-1:0]       w_from, w_to, w_diff;
    logic [VW-1:0]       w_stage_val;
    logic [EW-1:0]       w_n;
    logic                w_hit;
    logic                w_more;
    logic                w_stage_end;
    logic                w_last_stage;
    logic                w_out_free;
    logic [M_TDATA_W-1:0] w_out_data;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_opcode      = t_opcode'(s_axis_tuser[OPCODE_W-1:0]);
    assign w_stage_sel   = s_axis_tdata[STAGE_LSB +: STAGE_W];
    assign w_entry_index = s_axis_tdata[INDEX_LSB +: INDEX_W];
    assign w_entry_count = s_axis_tdata[COUNT_LSB +: COUNT_W];

    assign w_stage_ok = 32'(w_stage_sel) < STAGES;
    assign w_idx_ok   = 32'(w_entry_index) < ENTRIES;
    assign w_cnt_ok   = 32'(w_entry_count) <= ENTRIES;

    always_comb begin
        case (w_opcode)
            OP_WRITE: begin
                w_reject = !(w_stage_ok && w_idx_ok);
            end
            OP_FWD, OP_REV, OP_MINRST: begin
                w_reject = 1'b0;
            end
            OP_COUNT: begin
                w_reject = !(w_stage_ok && w_cnt_ok);
            end
            default: begin
                w_reject = 1'b1;
            end
        endcase
    end

    assign w_wr_addr = ADDR_W'(w_stage_sel) * ADDR_W'(ENTRIES) + ADDR_W'(w_entry_index);
    assign w_wr_data = {VW'(s_axis_tdata[DEST_LSB +: FIELD_W]),
                        VW'(s_axis_tdata[SRC_LSB +: FIELD_W]),
                        VW'(s_axis_tdata[LEN_LSB +: FIELD_W])};

    assign {w_dest, w_src, w_len} = w_rd_data;
    assign w_from       = r_rev ? w_dest : w_src;
    assign w_to         = r_rev ? w_src : w_dest;
    assign w_diff       = r_val - w_from;
    assign w_hit        = r_pend && (r_val >= w_from) && (w_diff < w_len);
    assign w_stage_val  = w_hit ? w_to + w_diff : r_val;
    assign w_n          = r_counts[r_stage];
    assign w_more       = r_ent < w_n;
    assign w_stage_end  = (r_state == S_MAP) && (w_hit || !w_more);
    assign w_last_stage = r_rev ? (r_stage == '0) : (r_stage == SW'(STAGES - 1));
    assign w_rd_addr    = ADDR_W'(r_stage) * ADDR_W'(ENTRIES) + ADDR_W'(r_ent);

    assign w_ctl.wr = w_accept && (w_opcode == OP_WRITE) && w_stage_ok && w_idx_ok;
    assign w_ctl.rd = (r_state == S_MAP) && !w_hit && w_more;

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        w_out_data = '0;
        w_out_data[MAPPED_LSB +: FIELD_W] = FIELD_W'(r_res_val);
        w_out_data[LOWEST_LSB +: FIELD_W] = FIELD_W'(r_min);
        w_out_data[STATUS_LSB]            = r_res_status;
    end

    crr_table #(
        .DEPTH  (DEPTH),
        .WIDTH  (3 * VW),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_opcode == OP_FWD || w_opcode == OP_REV) ? S_MAP : S_DONE;
                end
            end
            S_MAP: begin
                if (w_stage_end && w_last_stage) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_counts  <= '{default: '0};
            r_min     <= '1;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_val    <= '0;
                        r_res_status <= w_reject ? ST_REJECT : ST_OK;
                        r_val        <= VW'(s_axis_tdata[VALUE_LSB +: FIELD_W]);
                        r_ent        <= '0;
                        r_pend       <= 1'b0;
                        case (w_opcode)
                            OP_FWD: begin
                                r_rev   <= 1'b0;
                                r_stage <= '0;
                            end
                            OP_REV: begin
                                r_rev   <= 1'b1;
                                r_stage <= SW'(STAGES - 1);
                            end
                            OP_COUNT: begin
                                if (w_stage_ok && w_cnt_ok) begin
                                    r_counts[SW'(w_stage_sel)] <= EW'(w_entry_count);
                                end
                            end
                            OP_MINRST: begin
                                r_min <= '1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MAP: begin
                    if (w_stage_end) begin
                        r_val  <= w_stage_val;
                        r_ent  <= '0;
                        r_pend <= 1'b0;
                        if (w_last_stage) begin
                            r_res_val <= w_stage_val;
                            if (!r_rev && (w_stage_val < r_min)) begin
                                r_min <= w_stage_val;
                            end
                        end else begin
                            r_stage <= r_rev ? r_stage - 1'b1 : r_stage + 1'b1;
                        end
                    end else begin
                        r_ent  <= r_ent + 1'b1;
                        r_pend <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_data <= w_out_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

@@ rtl/crr_table.sv @@
// Entry memory: one write port, one registered read port.
module crr_table
    import crr_pkg::*;
#(
    parameter int DEPTH  = 224,
    parameter int WIDTH  = 96,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/crr_checker.sv @@
// Port-level checks for the chained range remap block and their binding.
module crr_checker
    import crr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_LSB] |->
            m_axis_tdata[MAPPED_LSB +: FIELD_W] == '0)
        else $error("rejected request carries a mapped value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind chained_range_remap crr_checker u_crr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
